// ===== rtl/sha1_counter_keystream_xor_top_assert.svh =====
// Assertion macros shared by the keystream cipher RTL.
`ifndef SHA1_COUNTER_KEYSTREAM_XOR_TOP_ASSERT_SVH
`define SHA1_COUNTER_KEYSTREAM_XOR_TOP_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define SKX_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define SKX_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== rtl/skx_pkg.sv =====
// Package with shared constants and types of the keystream cipher.
package skx_pkg;
    localparam int BLOCK_BYTES_DEFAULT = 16;
    localparam int DIGEST_BYTES = 20;
    localparam int KEY_WORDS = 7;
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_COUNTER_START = 3'd7;
    localparam logic [63:0] MSG_BITS = 64'h200;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_of_message;
    } item_t;

    function automatic logic [31:0] rc_k(input logic [6:0] r);
        logic [31:0] k;
        begin
            if (r < 7'd20) k = 32'h5A827999;
            else if (r < 7'd40) k = 32'h6ED9EBA1;
            else if (r < 7'd60) k = 32'h8F1BBCDC;
            else k = 32'hCA62C1D6;
            return k;
        end
    endfunction

    function automatic logic [31:0] rc_f(input logic [6:0] r, input logic [31:0] b,
                                         input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        begin
            if (r < 7'd20) f = (b & c) | (~b & d);
            else if (r < 7'd40) f = b ^ c ^ d;
            else if (r < 7'd60) f = (b & c) | (b & d) | (c & d);
            else f = b ^ c ^ d;
            return f;
        end
    endfunction
endpackage

// ===== rtl/sha1_counter_keystream_xor_top.sv =====
// Top level of the SHA-1 counter-mode keystream cipher.
//
// Input requests enter through push/full with data_byte and first_of_message.
// Results leave through empty/pop: out_byte is valid while empty is low and
// is taken when pop is high. Configuration writes use cfg_we, cfg_index and
// cfg_data; indexes 0 to 6 are key words, index 7 is the counter start.
// A two-entry queue holds requests while the back end works on one byte.
// A byte that uses a held keystream block passes from the idle state through
// the output state into the result register. The back end takes a new request
// only when idle with no result waiting, so never before the last byte is out.
// The first byte of each block first runs two 80-round SHA-1 compressions on a
// single round unit in the hash state before its output state.
// Reset clears the registers, counter, keystream, input queue and result register.
// While a result waits unpopped the back end takes no further request; the
// input queue keeps accepting until its two entries are full.
module sha1_counter_keystream_xor_top
#(
    parameter int BLOCK_BYTES = skx_pkg::BLOCK_BYTES_DEFAULT
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [7:0]                    data_byte,
    input  logic                          first_of_message,
    output logic                          empty,
    input  logic                          pop,
    output logic [7:0]                    out_byte,
    input  logic                          cfg_we,
    input  logic [skx_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]                   cfg_data
);
    import skx_pkg::*;

    item_t in_item, q_item;
    logic  q_avail, q_take;

    assign in_item.data_byte = data_byte;
    assign in_item.first_of_message = first_of_message;

    skx_front u_front
    (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .item_in(in_item),
        .take(q_take), .avail(q_avail), .item_out(q_item)
    );

    skx_back #(.BLOCK_BYTES(BLOCK_BYTES)) u_back
    (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .avail(q_avail), .item(q_item), .take(q_take),
        .empty(empty), .pop(pop), .out_byte(out_byte)
    );
endmodule

// ===== rtl/skx_front.sv =====
// Front part: accepts input requests into a two-entry queue.
module skx_front
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    output logic           full,
    input  skx_pkg::item_t item_in,
    input  logic           take,
    output logic           avail,
    output skx_pkg::item_t item_out
);
    import skx_pkg::*;

    item_t      mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       do_push, do_take;

    assign full = cnt_reg == 2'd2;
    assign avail = cnt_reg != 2'd0;
    assign item_out = mem_reg[rp_reg];
    assign do_push = push && !full;
    assign do_take = take && avail;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wp_reg] <= item_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (do_push) wp_reg <= ~wp_reg;
            if (do_take) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, do_push} - {1'b0, do_take};
        end
    end

    `include "sha1_counter_keystream_xor_top_assert.svh"
    `SKX_ASSERT_IMP(a_cnt_range, clk, rst_n, 1'b1, cnt_reg != 2'd3)
    `SKX_ASSERT_NEXT(a_full_hold, clk, rst_n, full && !take, full)
    `SKX_ASSERT_NEXT(a_empty_hold, clk, rst_n, !avail && !push, !avail)
endmodule

// ===== rtl/skx_back.sv =====
// Back part: SHA-1 keystream generation and byte XOR with an output register.
module skx_back
#(
    parameter int BLOCK_BYTES = skx_pkg::BLOCK_BYTES_DEFAULT
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [skx_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]               cfg_data,
    input  logic                      avail,
    input  skx_pkg::item_t            item,
    output logic                      take,
    output logic                      empty,
    input  logic                      pop,
    output logic [7:0]                out_byte
);
    import skx_pkg::*;

    localparam int LEN = (BLOCK_BYTES < 1) ? 1 :
                         ((BLOCK_BYTES > DIGEST_BYTES) ? DIGEST_BYTES : BLOCK_BYTES);
    localparam int PW = (LEN > 1) ? $clog2(LEN) : 1;
    localparam logic [PW-1:0] LAST = PW'(LEN - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_HASH = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    logic [63:0]  key_reg [KEY_WORDS];
    logic [63:0]  start_reg;
    logic [63:0]  ctr_reg, ctr_next;
    logic [159:0] ks_reg;
    logic [PW-1:0] pos_reg, pos_next;
    logic         ready_reg, ready_next;
    logic [1:0]   st_reg;
    logic         pass_reg;
    logic [6:0]   rnd_reg;
    logic [31:0]  w_reg [16];
    logic [31:0]  a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0]  h_reg [5];
    logic [7:0]   data_reg, ob_reg;
    logic         full_reg;
    logic [31:0]  wx, wnew, wcur, t;
    logic [7:0]   ksb;

    assign empty = !full_reg;
    assign out_byte = ob_reg;
    assign take = (st_reg == ST_IDLE) && avail && !full_reg;

    always_comb
    begin
        ctr_next = ctr_reg;
        pos_next = pos_reg;
        ready_next = ready_reg;
        if (item.first_of_message)
        begin
            ctr_next = start_reg;
            pos_next = '0;
            ready_next = 1'b0;
        end
    end

    assign wcur = w_reg[0];
    assign wx = w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0];
    assign wnew = {wx[30:0], wx[31]};
    assign t = {a_reg[26:0], a_reg[31:27]} + rc_f(rnd_reg, b_reg, c_reg, d_reg)
               + e_reg + rc_k(rnd_reg) + wcur;
    assign ksb = ks_reg[159 - 8 * int'(pos_reg) -: 8];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < KEY_WORDS; i++) key_reg[i] <= '0;
            start_reg <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_COUNTER_START) start_reg <= cfg_data;
            else key_reg[cfg_index] <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            data_reg <= item.data_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_IDLE;
            ctr_reg <= '0;
            pos_reg <= '0;
            ready_reg <= 1'b0;
            ks_reg <= '0;
            full_reg <= 1'b0;
            pass_reg <= 1'b0;
            rnd_reg <= '0;
            ob_reg <= '0;
            a_reg <= '0; b_reg <= '0; c_reg <= '0; d_reg <= '0; e_reg <= '0;
            for (int i = 0; i < 16; i++) w_reg[i] <= '0;
            for (int i = 0; i < 5; i++) h_reg[i] <= '0;
        end
        else
        begin
            if (pop && full_reg) full_reg <= 1'b0;
            case (st_reg)
                ST_IDLE:
                begin
                    if (take)
                    begin
                        ctr_reg <= ctr_next;
                        pos_reg <= pos_next;
                        ready_reg <= ready_next;
                        if (!ready_next)
                        begin
                            // First pass hashes the key words and the counter.
                            for (int i = 0; i < KEY_WORDS; i++)
                            begin
                                w_reg[2*i] <= key_reg[i][63:32];
                                w_reg[2*i+1] <= key_reg[i][31:0];
                            end
                            w_reg[14] <= ctr_next[63:32];
                            w_reg[15] <= ctr_next[31:0];
                            h_reg[0] <= 32'h67452301; a_reg <= 32'h67452301;
                            h_reg[1] <= 32'hEFCDAB89; b_reg <= 32'hEFCDAB89;
                            h_reg[2] <= 32'h98BADCFE; c_reg <= 32'h98BADCFE;
                            h_reg[3] <= 32'h10325476; d_reg <= 32'h10325476;
                            h_reg[4] <= 32'hC3D2E1F0; e_reg <= 32'hC3D2E1F0;
                            pass_reg <= 1'b0;
                            rnd_reg <= '0;
                            st_reg <= ST_HASH;
                        end
                        else
                        begin
                            st_reg <= ST_OUT;
                        end
                    end
                end
                ST_HASH:
                begin
                    e_reg <= d_reg;
                    d_reg <= c_reg;
                    c_reg <= {b_reg[1:0], b_reg[31:2]};
                    b_reg <= a_reg;
                    a_reg <= t;
                    for (int i = 0; i < 15; i++) w_reg[i] <= w_reg[i+1];
                    w_reg[15] <= wnew;
                    rnd_reg <= rnd_reg + 7'd1;
                    if (rnd_reg == 7'd79)
                    begin
                        h_reg[0] <= h_reg[0] + t;
                        h_reg[1] <= h_reg[1] + a_reg;
                        h_reg[2] <= h_reg[2] + {b_reg[1:0], b_reg[31:2]};
                        h_reg[3] <= h_reg[3] + c_reg;
                        h_reg[4] <= h_reg[4] + d_reg;
                        a_reg <= h_reg[0] + t;
                        b_reg <= h_reg[1] + a_reg;
                        c_reg <= h_reg[2] + {b_reg[1:0], b_reg[31:2]};
                        d_reg <= h_reg[3] + c_reg;
                        e_reg <= h_reg[4] + d_reg;
                        rnd_reg <= '0;
                        if (!pass_reg)
                        begin
                            // Second pass hashes the fixed padding block.
                            pass_reg <= 1'b1;
                            w_reg[0] <= 32'h80000000;
                            for (int i = 1; i < 14; i++) w_reg[i] <= '0;
                            w_reg[14] <= MSG_BITS[63:32];
                            w_reg[15] <= MSG_BITS[31:0];
                        end
                        else
                        begin
                            ks_reg <= {h_reg[0] + t, h_reg[1] + a_reg,
                                       h_reg[2] + {b_reg[1:0], b_reg[31:2]},
                                       h_reg[3] + c_reg, h_reg[4] + d_reg};
                            ready_reg <= 1'b1;
                            st_reg <= ST_OUT;
                        end
                    end
                end
                ST_OUT:
                begin
                    ob_reg <= data_reg ^ ksb;
                    full_reg <= 1'b1;
                    st_reg <= ST_IDLE;
                    if (pos_reg == LAST)
                    begin
                        pos_reg <= '0;
                        ctr_reg <= ctr_reg + 64'd1;
                        ready_reg <= 1'b0;
                    end
                    else
                    begin
                        pos_reg <= pos_reg + PW'(1);
                    end
                end
                default:
                begin
                    st_reg <= ST_IDLE;
                end
            endcase
        end
    end

    `include "sha1_counter_keystream_xor_top_assert.svh"
    `SKX_ASSERT_IMP(a_out_from_idle, clk, rst_n, st_reg == ST_OUT, !full_reg || pop)
    `SKX_ASSERT_IMP(a_round_range, clk, rst_n, 1'b1, rnd_reg < 7'd80)
    `SKX_ASSERT_NEXT(a_out_sets_full, clk, rst_n, st_reg == ST_OUT, full_reg)
    `SKX_ASSERT_IMP(a_pos_range, clk, rst_n, 1'b1, pos_reg <= LAST)
endmodule

// ===== tb/tb.sv =====
// Testbench for the SHA-1 counter-mode keystream cipher top level.
`timescale 1ns / 100ps

module tb;
    import skx_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 400;

    logic                 clk;
    logic                 rst_n;
    logic                 push;
    logic                 full;
    logic [7:0]           data_byte;
    logic                 first_of_message;
    logic                 empty;
    logic                 pop;
    logic [7:0]           out_byte;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [63:0]          cfg_data;

    sha1_counter_keystream_xor_top uut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .data_byte(data_byte), .first_of_message(first_of_message),
        .empty(empty), .pop(pop), .out_byte(out_byte),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Predictor state.
    logic [63:0]  key_regs [KEY_WORDS];
    logic [63:0]  start_reg;
    logic [63:0]  blk_count;
    logic [159:0] digest;
    int           byte_pos;
    bit           digest_valid;

    logic [7:0] out_bytes_due [$];
    int         send_idle_pct;
    int         recv_idle_pct;
    int         errors;
    int         quiet_cycles;

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [31:0] rol(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic void sha1_block(ref logic [31:0] h [5], input logic [511:0] blk);
        logic [31:0] w [80];
        logic [31:0] a, b, c, d, e, f, k, t;
        for (int i = 0; i < 16; i++) w[i] = blk[511 - 32 * i -: 32];
        for (int i = 16; i < 80; i++) w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
        a = h[0]; b = h[1]; c = h[2]; d = h[3]; e = h[4];
        for (int i = 0; i < 80; i++)
        begin
            if (i < 20) begin f = (b & c) | (~b & d); k = 32'h5A827999; end
            else if (i < 40) begin f = b ^ c ^ d; k = 32'h6ED9EBA1; end
            else if (i < 60) begin f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC; end
            else begin f = b ^ c ^ d; k = 32'hCA62C1D6; end
            t = rol(a, 5) + f + e + k + w[i];
            e = d; d = c; c = rol(b, 30); b = a; a = t;
        end
        h[0] += a; h[1] += b; h[2] += c; h[3] += d; h[4] += e;
    endfunction

    function automatic logic [159:0] counter_digest(input logic [63:0] ctr);
        logic [31:0]  h [5];
        logic [511:0] msg;
        logic [511:0] pad;
        h = '{32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0};
        for (int i = 0; i < KEY_WORDS; i++) msg[511 - 64 * i -: 64] = key_regs[i];
        msg[63:0] = ctr;
        pad = '0;
        pad[511:504] = 8'h80;
        pad[63:0] = MSG_BITS;
        sha1_block(h, msg);
        sha1_block(h, pad);
        return {h[0], h[1], h[2], h[3], h[4]};
    endfunction

    function automatic logic [7:0] cipher_byte(input logic [7:0] d, input bit first);
        logic [7:0] r;
        if (first)
        begin
            blk_count = start_reg;
            byte_pos = 0;
            digest_valid = 0;
        end
        if (!digest_valid)
        begin
            digest = counter_digest(blk_count);
            digest_valid = 1;
        end
        r = d ^ digest[159 - 8 * byte_pos -: 8];
        byte_pos++;
        if (byte_pos >= BLOCK_BYTES_DEFAULT)
        begin
            byte_pos = 0;
            blk_count++;
            digest_valid = 0;
        end
        return r;
    endfunction

    // Push stays high between back-to-back requests; it drops only when idling.
    task automatic send_byte(input logic [7:0] d, input bit first);
        int idle;
        idle = 0;
        while ($urandom_range(99) < send_idle_pct) idle++;
        if (idle > 0)
        begin
            push <= 1'b0;
            repeat (idle) @(posedge clk);
        end
        push <= 1'b1;
        data_byte <= d;
        first_of_message <= first;
        out_bytes_due.push_back(cipher_byte(d, first));
        @(posedge clk);
        while (full) @(posedge clk);
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        while (out_bytes_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input int idx, input logic [63:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx[CFG_IDX_W-1:0];
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == int'(REG_COUNTER_START)) start_reg = val;
        else key_regs[idx] = val;
        @(posedge clk);
    endtask

    task automatic load_keys(input int mode);
        logic [63:0] v;
        for (int i = 0; i <= KEY_WORDS; i++)
        begin
            if (mode == 0) v = '0;
            else if (mode == 1) v = '1;
            else v = {$urandom, $urandom};
            write_reg(i, v);
        end
    endtask

    // Bytes before any first flag run from the reset counter of zero.
    task automatic test_reset_defaults();
        for (int i = 0; i < 18; i++) send_byte(i[0] ? 8'hFF : 8'h00, 1'b0);
        wait_idle();
    endtask

    task automatic test_extremes();
        load_keys(1);
        write_reg(int'(REG_COUNTER_START), 64'hFFFF_FFFF_FFFF_FFFF);
        send_byte(8'hA5, 1'b1);
        for (int i = 0; i < 20; i++) send_byte(8'($urandom_range(255)), 1'b0);
        // A key write in mid-block must wait for the next digest.
        wait_idle();
        write_reg(0, 64'h0123_4567_89AB_CDEF);
        for (int i = 0; i < 14; i++) send_byte(8'($urandom_range(255)), 1'b0);
        wait_idle();
    endtask

    task automatic test_random_traffic(input int n);
        int len;
        while (n > 0)
        begin
            len = $urandom_range(4) == 0 ? $urandom_range(40, 1) : $urandom_range(8, 1);
            send_byte(8'($urandom_range(255)), 1'b1);
            for (int i = 1; i < len; i++)
                send_byte(8'($urandom_range(255)), $urandom_range(30) == 0);
            n -= len;
        end
        wait_idle();
    endtask

    initial begin
        rst_n = 1'b0;
        push = 1'b0;
        data_byte = '0;
        first_of_message = 1'b0;
        pop = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        errors = 0;
        send_idle_pct = 8;
        recv_idle_pct = 68;
        for (int i = 0; i < KEY_WORDS; i++) key_regs[i] = '0;
        start_reg = '0;
        blk_count = '0;
        digest = '0;
        byte_pos = 0;
        digest_valid = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_extremes();
        load_keys(0);
        test_random_traffic(100);
        load_keys(2);
        test_random_traffic(160);
        send_idle_pct = 68;
        recv_idle_pct = 8;
        load_keys(2);
        test_random_traffic(220);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        load_keys(2);
        test_random_traffic(250);

        if (errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

    // Result checker with random receive stalls.
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (out_bytes_due.size() == 0)
            begin
                $error("out_byte: expected none, actual %02h", out_byte);
                errors++;
            end
            else if (out_byte !== out_bytes_due[0])
            begin
                $error("out_byte: expected %02h, actual %02h", out_bytes_due[0], out_byte);
                errors++;
                void'(out_bytes_due.pop_front());
            end
            else
                void'(out_bytes_due.pop_front());
        end
        pop <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || out_bytes_due.size() == 0)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WATCHDOG_LIMIT)
        begin
            $display("tb: done, errors");
            $finish;
        end
    end

    initial quiet_cycles = 0;
endmodule

// ===== files.f =====
+incdir+rtl
rtl/skx_pkg.sv
rtl/skx_front.sv
rtl/skx_back.sv
rtl/sha1_counter_keystream_xor_top.sv
tb/tb.sv
